>>> sv/gtm_pkg.sv
// shared types, microcode constants and control store of the gcd core
package gtm_pkg;

  localparam int unsigned OutWidth = 16;
  localparam int unsigned PcWidth  = 3;

  // method register codes
  localparam logic [1:0] METHOD_REM = 2'd0;
  localparam logic [1:0] METHOD_SUB = 2'd1;
  localparam logic [1:0] METHOD_CNT = 2'd2;

  // microcode addresses
  localparam logic [PcWidth-1:0] PC_IDLE  = 3'd0;
  localparam logic [PcWidth-1:0] PC_TEST  = 3'd1;
  localparam logic [PcWidth-1:0] PC_DINIT = 3'd2;
  localparam logic [PcWidth-1:0] PC_DSTEP = 3'd3;
  localparam logic [PcWidth-1:0] PC_DEND  = 3'd4;
  localparam logic [PcWidth-1:0] PC_DONE  = 3'd5;
  localparam logic [PcWidth-1:0] PC_BACK  = 3'd6;

  typedef enum logic [2:0] {
    OP_NOP    = 3'd0,
    OP_LOAD   = 3'd1,
    OP_DINIT  = 3'd2,
    OP_DSTEP  = 3'd3,
    OP_DEND   = 3'd4,
    OP_FINISH = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    COND_ALWAYS    = 3'd0,
    COND_NO_INPUT  = 3'd1,
    COND_N_ZERO    = 3'd2,
    COND_BITS_LEFT = 3'd3,
    COND_OUT_BUSY  = 3'd4
  } cond_e;

  typedef struct packed {
    cond_e              cond;
    logic [PcWidth-1:0] target;
    op_e                op;
  } ucode_t;

  typedef struct packed {
    logic n_zero;
    logic bits_left;
    logic out_busy;
  } dp_status_t;

  // control store: jump to target when cond holds, else fall through
  function automatic ucode_t ucode_rom(input logic [PcWidth-1:0] pc);
    ucode_t w;
    case (pc)
      PC_IDLE:  w = '{cond: COND_NO_INPUT,  target: PC_IDLE,  op: OP_LOAD};
      PC_TEST:  w = '{cond: COND_N_ZERO,    target: PC_DONE,  op: OP_NOP};
      PC_DINIT: w = '{cond: COND_ALWAYS,    target: PC_DSTEP, op: OP_DINIT};
      PC_DSTEP: w = '{cond: COND_BITS_LEFT, target: PC_DSTEP, op: OP_DSTEP};
      PC_DEND:  w = '{cond: COND_ALWAYS,    target: PC_TEST,  op: OP_DEND};
      PC_DONE:  w = '{cond: COND_OUT_BUSY,  target: PC_DONE,  op: OP_FINISH};
      PC_BACK:  w = '{cond: COND_ALWAYS,    target: PC_IDLE,  op: OP_NOP};
      default:  w = '{cond: COND_ALWAYS,    target: PC_IDLE,  op: OP_NOP};
    endcase
    return w;
  endfunction

endpackage

>>> sv/gcd_three_methods_core.sv
// top level of the three-method gcd core
//
// Greatest common divisor of two unsigned 16-bit words with a selectable method
// (method register: 0 remainder Euclid, 1 subtractive Euclid, 2 countdown from
// the smaller operand; code 3 acts as 0). Every method shares one remainder
// Euclid run; the subtractive and countdown iteration counts follow from its
// quotient sum, the smaller operand and the gcd, saturated at 65535. Methods 1
// and 2 return gcd 0, count 0 and zero_error on a zero operand. Operands are
// reduced modulo 2^DATA_WIDTH. A small microcode program in a control store
// steps a plain datapath; each remainder step runs a bit-serial restoring
// divider, one quotient bit per cycle. A word takes at most 23 remainder
// steps for 16-bit operands, and a finished result waits for out_ready_i
// while the previous one is still held. A new word is taken only at the
// idle step; the result register lets the next word be accepted while a
// result waits.
// Write the method register only while the core is idle.
module gcd_three_methods_core import gtm_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_wdata_i,
  // input words
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OutWidth-1:0] first_value_i,
  input  logic [OutWidth-1:0] second_value_i,
  // result words
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutWidth-1:0] gcd_value_o,
  output logic [OutWidth-1:0] iteration_count_o,
  output logic                zero_error_o
);

  logic [1:0] method_q, method_d;
  op_e        op;
  dp_status_t status;

  // method register, no read-back
  assign method_d = cfg_we_i ? cfg_wdata_i : method_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= METHOD_REM;
    end else begin
      method_q <= method_d;
    end
  end

  // a word is taken only while the program sits in its idle step
  assign in_ready_o = (op == OP_LOAD);

  gtm_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .op_o       (op)
  );

  gtm_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .op_i              (op),
    .method_i          (method_q),
    .in_valid_i        (in_valid_i),
    .first_value_i     (first_value_i),
    .second_value_i    (second_value_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .gcd_value_o       (gcd_value_o),
    .iteration_count_o (iteration_count_o),
    .zero_error_o      (zero_error_o),
    .status_o          (status)
  );

endmodule

>>> sv/gtm_useq.sv
// microcode sequencer: step counter, control store and jump logic
module gtm_useq import gtm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  dp_status_t status_i,
  output op_e        op_o
);

  logic [PcWidth-1:0] pc_q, pc_d;
  ucode_t             uw;
  logic               take;

  assign uw   = ucode_rom(pc_q);
  assign op_o = uw.op;

  always_comb begin
    case (uw.cond)
      COND_ALWAYS:    take = 1'b1;
      COND_NO_INPUT:  take = !in_valid_i;
      COND_N_ZERO:    take = status_i.n_zero;
      COND_BITS_LEFT: take = status_i.bits_left;
      COND_OUT_BUSY:  take = status_i.out_busy;
      default:        take = 1'b1;
    endcase
    pc_d = take ? uw.target : pc_q + 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_pc_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= PC_BACK)
    else $error("step counter left the program");

  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == PC_DSTEP && !status_i.bits_left) |=> (pc_q == PC_DEND))
    else $error("divide loop did not exit to its end step");
`endif

endmodule

>>> sv/gtm_datapath.sv
// datapath: operand registers, bit-serial divider, counters and result word
module gtm_datapath import gtm_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  op_e                 op_i,
  input  logic [1:0]          method_i,
  input  logic                in_valid_i,
  input  logic [OutWidth-1:0] first_value_i,
  input  logic [OutWidth-1:0] second_value_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [OutWidth-1:0] gcd_value_o,
  output logic [OutWidth-1:0] iteration_count_o,
  output logic                zero_error_o,
  output dp_status_t          status_o
);

  localparam int unsigned DW   = DATA_WIDTH;
  localparam int unsigned CntW = (DW > 1) ? $clog2(DW) : 1;
  localparam int unsigned QsW  = OutWidth + 1;

  logic [DW-1:0]   m_q, m_d, n_q, n_d, rem_q, rem_d, mn_q, mn_d;
  logic [CntW-1:0] bit_q, bit_d;
  logic [QsW-1:0]  qsum_q, qsum_d;
  logic [OutWidth-1:0] steps_q, steps_d;
  logic            zero_q, zero_d;
  logic            out_valid_q, out_valid_d;
  logic [OutWidth-1:0] gcd_q, gcd_d, cnt_q, cnt_d;
  logic            err_q, err_d;

  logic [DW+OutWidth-1:0] a_ext, b_ext, g_ext;
  logic [DW-1:0]   a_op, b_op;
  logic [DW:0]     shifted, trial;
  logic            qbit;
  logic [DW+QsW:0] qs_sum;
  logic [DW-1:0]   cnt_diff;
  logic [DW:0]     cnt_m2;
  logic [DW+OutWidth:0] cnt_m2_ext;
  logic [OutWidth-1:0] cnt_sub, cnt_cnt;
  logic            load_fire, finish_fire, out_busy;

  assign out_busy    = out_valid_q && !out_ready_i;
  assign load_fire   = (op_i == OP_LOAD) && in_valid_i;
  assign finish_fire = (op_i == OP_FINISH) && !out_busy;

  // operands are reduced modulo 2^DATA_WIDTH
  assign a_ext = {{DW{1'b0}}, first_value_i};
  assign b_ext = {{DW{1'b0}}, second_value_i};
  assign a_op  = a_ext[DW-1:0];
  assign b_op  = b_ext[DW-1:0];

  // one restoring divide step
  assign shifted = {rem_q, m_q[DW-1]};
  assign trial   = shifted - {1'b0, n_q};
  assign qbit    = (shifted >= {1'b0, n_q});

  // saturating quotient sum
  assign qs_sum = {{(DW+1){1'b0}}, qsum_q} + {{(QsW+1){1'b0}}, m_q};

  // countdown count: min - gcd + 1, or min - 1 when gcd is 1
  assign cnt_diff   = mn_q - m_q;
  assign cnt_m2     = {1'b0, cnt_diff} + {{DW{1'b0}}, (m_q != {{(DW-1){1'b0}}, 1'b1})};
  assign cnt_m2_ext = {{OutWidth{1'b0}}, cnt_m2};
  assign cnt_cnt    = (|cnt_m2_ext[DW+OutWidth:OutWidth]) ? '1 : cnt_m2_ext[OutWidth-1:0];
  assign cnt_sub    = qsum_q[QsW-1] ? '1 : qsum_q[OutWidth-1:0] - 16'd1;
  assign g_ext      = {{OutWidth{1'b0}}, m_q};

  always_comb begin
    m_d         = m_q;
    n_d         = n_q;
    rem_d       = rem_q;
    mn_d        = mn_q;
    bit_d       = bit_q;
    qsum_d      = qsum_q;
    steps_d     = steps_q;
    zero_d      = zero_q;
    out_valid_d = out_valid_q && !out_ready_i;
    gcd_d       = gcd_q;
    cnt_d       = cnt_q;
    err_d       = err_q;
    case (op_i)
      OP_LOAD: begin
        if (load_fire) begin
          m_d     = a_op;
          n_d     = b_op;
          mn_d    = (a_op < b_op) ? a_op : b_op;
          zero_d  = (a_op == '0) || (b_op == '0);
          qsum_d  = '0;
          steps_d = '0;
        end
      end
      OP_DINIT: begin
        rem_d = '0;
        bit_d = CntW'(DW - 1);
      end
      OP_DSTEP: begin
        rem_d = qbit ? trial[DW-1:0] : shifted[DW-1:0];
        m_d   = {m_q[DW-2:0], qbit};
        bit_d = bit_q - CntW'(1);
      end
      OP_DEND: begin
        qsum_d  = (|qs_sum[DW+QsW:QsW]) ? '1 : qs_sum[QsW-1:0];
        steps_d = (steps_q == '1) ? steps_q : steps_q + 16'd1;
        m_d     = n_q;
        n_d     = rem_q;
      end
      OP_FINISH: begin
        if (finish_fire) begin
          out_valid_d = 1'b1;
          case (method_i)
            METHOD_SUB, METHOD_CNT: begin
              if (zero_q) begin
                gcd_d = '0;
                cnt_d = '0;
                err_d = 1'b1;
              end else begin
                gcd_d = g_ext[OutWidth-1:0];
                cnt_d = (method_i == METHOD_SUB) ? cnt_sub : cnt_cnt;
                err_d = 1'b0;
              end
            end
            default: begin
              gcd_d = g_ext[OutWidth-1:0];
              cnt_d = steps_q;
              err_d = 1'b0;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q     <= m_d;
    n_q     <= n_d;
    rem_q   <= rem_d;
    mn_q    <= mn_d;
    bit_q   <= bit_d;
    qsum_q  <= qsum_d;
    steps_q <= steps_d;
    zero_q  <= zero_d;
    gcd_q   <= gcd_d;
    cnt_q   <= cnt_d;
    err_q   <= err_d;
  end

  assign status_o.n_zero    = (n_q == '0);
  assign status_o.bits_left = (bit_q != '0);
  assign status_o.out_busy  = out_busy;

  assign out_valid_o       = out_valid_q;
  assign gcd_value_o       = gcd_q;
  assign iteration_count_o = cnt_q;
  assign zero_error_o      = err_q;

`ifndef NO_ASSERTIONS
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_DSTEP) |-> (n_q != '0 && rem_q < n_q))
    else $error("divide step with zero divisor or unreduced remainder");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(op_i == OP_FINISH))
    else $error("result word raised outside the finish step");
`endif

endmodule
